### src/tcg_pkg.sv
package tcg_pkg;

  localparam int TEXT_COLUMNS_DEF = 80;
  localparam int TEXT_ROWS_DEF    = 48;
  localparam int GLYPH_LINES_DEF  = 16;

  localparam int FONT_CHARS  = 128;
  localparam int FONT_LINES  = 16;
  localparam int FONT_DEPTH  = FONT_CHARS * FONT_LINES;
  localparam int FONT_ADDR_W = $clog2(FONT_DEPTH);
  localparam int CODE_W      = $clog2(FONT_CHARS);
  localparam int LINE_W      = $clog2(FONT_LINES);

  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int COLOR_W = 24;
  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TEXT = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;
  localparam logic [1:0] KIND_SOF  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COLOR = 2'd1;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST  = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] BLOCK_COLOR_RST = 24'h808080;

  // UTF-8 lead byte patterns.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;

  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;
  localparam logic [7:0] SOLID_MASK = 8'd255;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [FONT_ADDR_W-1:0] addr;
    logic [7:0]             wdata;
  } font_req_t;

endpackage

### src/tcg_if.sv
interface tcg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [3:0] load_line;
  logic [7:0] load_bits;

  modport source (output valid, kind, value, load_line, load_bits, input ready);
  modport sink (input valid, kind, value, load_line, load_bits, output ready);
endinterface

interface tcg_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cell_column;
  logic [5:0] text_row;
  logic [3:0] glyph_line;
  logic [7:0] pixel_mask;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;

  modport source (output valid, cell_column, text_row, glyph_line, pixel_mask, red, green,
                  blue, last, input ready);
  modport sink (input valid, cell_column, text_row, glyph_line, pixel_mask, red, green,
                blue, last, output ready);
endinterface

interface tcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/text_cell_glyph_renderer_top.sv
// Text-mode character generator for 8x16 glyph cells.
// The item channel carries four kinds of beat: a glyph row load that writes
// one line of the font memory, a text byte, an end of line and a start of
// frame. The result channel carries one beat per glyph line of a drawn cell:
// its column, row, line, pixel mask, color and a last flag on the final line.
// The cfg channel writes the text color (index 0) and the block color
// (index 1); it is always ready and should only be used while the block idles.
// A printable byte or a byte with bit 7 set, such as a UTF-8 lead byte, inside
// the frame yields GLYPH_LINES result beats, one per cycle from the font memory
// read port while the receiver keeps up; each line passes the memory read
// register and then the output register. The next item is taken once the last
// line has left the read stage. Loads, control bytes, skipped bytes and line or
// frame items draw no lines.
// After reset the font memory is cleared one entry per cycle, all 2048 entries,
// and the item channel is not ready until that pass is done. Cursor and
// skip count reset to zero, the colors to white and mid gray.
// When the receiver stalls, the output register holds its beat and one more
// line waits in the memory read register; no line is lost or repeated.
module text_cell_glyph_renderer_top #(
  parameter int TEXT_COLUMNS = tcg_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = tcg_pkg::TEXT_ROWS_DEF,
  parameter int GLYPH_LINES  = tcg_pkg::GLYPH_LINES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tcg_in_if.sink    item,
  tcg_out_if.source result,
  tcg_cfg_if.sink   cfg
);
  import tcg_pkg::*;

  logic [COLOR_W-1:0] text_color;
  logic [COLOR_W-1:0] block_color;
  font_req_t          req;
  logic [7:0]         rd_data;
  logic               clr_busy;

  // Configuration registers; writes to other indexes are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color  <= TEXT_COLOR_RST;
      block_color <= BLOCK_COLOR_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_TEXT_COLOR) begin
        text_color <= cfg.data;
      end else if (cfg.index == REG_BLOCK_COLOR) begin
        block_color <= cfg.data;
      end
    end
  end

  // The sequencer owns the cursor and walks the lines of a cell.
  tcg_seq #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .GLYPH_LINES  (GLYPH_LINES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .text_color  (text_color),
    .block_color (block_color),
    .clr_busy    (clr_busy),
    .rd_data     (rd_data),
    .req         (req)
  );

  // Font memory with its clearing pass after reset.
  tcg_font_mem u_font_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

endmodule

### src/tcg_font_mem.sv
module tcg_font_mem (
  input  logic              clk,
  input  logic              rst,
  input  tcg_pkg::font_req_t req,
  output logic [7:0]        rd_data,
  output logic              clr_busy
);
  import tcg_pkg::*;

  logic [7:0]             mem [FONT_DEPTH];
  logic [FONT_ADDR_W-1:0] clr_addr;

  // Clearing pass after reset: one entry per cycle until every glyph is blank.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == FONT_ADDR_W'(FONT_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= 8'd0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

### src/tcg_seq.sv
module tcg_seq #(
  parameter int TEXT_COLUMNS = tcg_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = tcg_pkg::TEXT_ROWS_DEF,
  parameter int GLYPH_LINES  = tcg_pkg::GLYPH_LINES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  tcg_in_if.sink                       item,
  tcg_out_if.source                    result,
  input  logic [tcg_pkg::COLOR_W-1:0]  text_color,
  input  logic [tcg_pkg::COLOR_W-1:0]  block_color,
  input  logic                         clr_busy,
  input  logic [7:0]                   rd_data,
  output tcg_pkg::font_req_t           req
);
  import tcg_pkg::*;

  localparam logic [COL_W-1:0]  COLS_V    = COL_W'(TEXT_COLUMNS);
  localparam logic [ROW_W-1:0]  ROWS_V    = ROW_W'(TEXT_ROWS);
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(GLYPH_LINES - 1);

  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [1:0]         skip;
  logic               active;
  logic [LINE_W-1:0]  issue_line;
  logic [COL_W-1:0]   cell_col;
  logic [ROW_W-1:0]   cell_row;
  logic [CODE_W-1:0]  code;
  logic               solid;
  logic [COLOR_W-1:0] color;
  logic               p_valid;
  logic [LINE_W-1:0]  p_line;

  logic       acc;
  logic       in_frame;
  logic       is_print;
  logic [1:0] lead_skip;
  logic       load_out;
  logic       issue;

  assign item.ready = !clr_busy && !active && !p_valid;
  assign acc        = item.valid && item.ready;

  assign in_frame = (cur_row < ROWS_V) && (cur_col < COLS_V);
  assign is_print = (item.value >= PRINT_LO) && (item.value <= PRINT_HI);

  always_comb begin
    if ((item.value & LEAD2_MASK) == LEAD2_VAL) begin
      lead_skip = 2'd1;
    end else if ((item.value & LEAD3_MASK) == LEAD3_VAL) begin
      lead_skip = 2'd2;
    end else if ((item.value & LEAD4_MASK) == LEAD4_VAL) begin
      lead_skip = 2'd3;
    end else begin
      lead_skip = 2'd0;
    end
  end

  // The read data register acts as a stage between issue and the output register.
  assign load_out = p_valid && (!result.valid || result.ready);
  assign issue    = active && (!p_valid || load_out);

  always_comb begin
    req.we    = acc && (item.kind == KIND_LOAD) && !item.value[7];
    req.re    = issue;
    req.wdata = item.load_bits;
    if (issue) begin
      req.addr = {code, issue_line};
    end else begin
      req.addr = {item.value[CODE_W-1:0], item.load_line};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= '0;
      cur_row    <= '0;
      skip       <= '0;
      active     <= 1'b0;
      issue_line <= '0;
    end else if (acc) begin
      case (item.kind)
        KIND_EOL: begin
          cur_col <= '0;
          skip    <= '0;
          if (cur_row < ROWS_V) begin
            cur_row <= cur_row + 1'b1;
          end
        end
        KIND_SOF: begin
          cur_col <= '0;
          cur_row <= '0;
          skip    <= '0;
        end
        KIND_TEXT: begin
          if (in_frame) begin
            if (skip != 2'd0) begin
              skip <= skip - 1'b1;
            end else begin
              cur_col    <= cur_col + 1'b1;
              cell_col   <= cur_col;
              cell_row   <= cur_row;
              code       <= item.value[CODE_W-1:0];
              issue_line <= '0;
              if (item.value[7]) begin
                active <= 1'b1;
                solid  <= 1'b1;
                color  <= block_color;
                skip   <= lead_skip;
              end else if (is_print) begin
                active <= 1'b1;
                solid  <= 1'b0;
                color  <= text_color;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else if (issue) begin
      if (issue_line == LAST_LINE) begin
        active <= 1'b0;
      end else begin
        issue_line <= issue_line + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (issue) begin
      p_valid <= 1'b1;
      p_line  <= issue_line;
    end else if (load_out) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid       <= 1'b1;
      result.cell_column <= cell_col;
      result.text_row    <= cell_row;
      result.glyph_line  <= p_line;
      result.pixel_mask  <= solid ? SOLID_MASK : rd_data;
      result.red         <= color[23:16];
      result.green       <= color[15:8];
      result.blue        <= color[7:0];
      result.last        <= (p_line == LAST_LINE);
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule
